### src/slbm_pkg.sv
// ----------------------------------------------------------------------------
// slbm_pkg
// Shared types and constants for the serial-load bank mapper.
// ----------------------------------------------------------------------------
package slbm_pkg;

  // Bus access codes
  typedef enum logic [1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU_RD = 2'd2,
    CMD_PPU_WR = 2'd3
  } slbm_cmd_t;

  // Mirroring codes
  typedef enum logic [2:0] {
    MIR_POWERUP  = 3'd0,
    MIR_ONE_LO   = 3'd1,
    MIR_ONE_HI   = 3'd2,
    MIR_VERTICAL = 3'd3,
    MIR_HORIZ    = 3'd4
  } slbm_mirror_t;

  // Target register picked by address bits 14:13 on the fifth serial bit
  typedef enum logic [1:0] {
    TGT_CONTROL = 2'd0,
    TGT_CHR0    = 2'd1,
    TGT_CHR1    = 2'd2,
    TGT_PRG     = 2'd3
  } slbm_target_t;

  localparam int unsigned MapW  = 23;
  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;
  localparam int unsigned CfgAw = 3;
  localparam int unsigned CfgDw = 32;

  // Configuration register byte addresses
  localparam logic [CfgAw-1:0] CFG_ADDR_PRG_COUNT = 3'd0;
  localparam logic [CfgAw-1:0] CFG_ADDR_CHR_COUNT = 3'd4;

  // Reset values
  localparam logic [7:0] PRG_COUNT_RST = 8'd2;
  localparam logic [7:0] CHR_COUNT_RST = 8'd0;
  localparam logic [4:0] CONTROL_RST   = 5'h1C;

  localparam logic [2:0]     SHIFT_FULL  = 3'd5;
  localparam logic [MapW-1:0] BANK16_OFS = 23'h004000;

endpackage

### src/serial_load_bank_mapper_top.sv
// ----------------------------------------------------------------------------
// serial_load_bank_mapper_top
// Serial-load cartridge bank mapper: serial register loader plus CPU and PPU
// address translation.
// ----------------------------------------------------------------------------
// Usage: every bus access (CPU read/write, PPU read/write) is one transfer on
// the in_ channel and yields exactly one transfer on the out_ channel. The
// block is a two-register pipeline: an input register, then the translation
// and serial-register update, then the result register. One access is taken
// every clock while in_stall is low; out_valid rises when it reaches the
// result register. A stalled output only back-pressures the input once both
// registers are full. Mapping of an access uses the bank registers as left by
// all earlier accesses; out_mirroring reports the state after the access itself.
// prg_bank_count and chr_bank_count are written over the APB port (offsets
// 0x0 and 0x4); the user writes them while no access is in flight, the block does not enforce this.
// ----------------------------------------------------------------------------
module serial_load_bank_mapper_top
  import slbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // access input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [AddrW-1:0]      in_address,
  input  logic [DataW-1:0]      in_write_data,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MapW-1:0]       out_mapped_address,
  output logic                  out_pass_through,
  output logic [2:0]            out_mirroring,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CfgAw-1:0]      paddr,
  input  logic [CfgDw-1:0]      pwdata,
  output logic [CfgDw-1:0]      prdata,
  output logic                  pready
);

  // configuration registers
  logic [7:0] prg_count_r;
  logic [7:0] chr_count_r;

  // mapper state
  logic [4:0] shift_r,  shift_nxt;
  logic [2:0] count_r,  count_nxt;
  logic [4:0] ctrl_r,   ctrl_nxt;
  logic [4:0] chr0_r,   chr0_nxt;
  logic [4:0] chr1_r,   chr1_nxt;
  logic [4:0] prg_r,    prg_nxt;
  logic [2:0] mirror_r, mirror_nxt;

  // input stage
  logic             s1_valid_r;
  slbm_cmd_t        s1_cmd_r;
  logic [AddrW-1:0] s1_addr_r;
  logic [DataW-1:0] s1_data_r;

  // result stage
  logic            out_valid_r;
  logic [MapW-1:0] out_map_r, map_nxt;
  logic            out_pass_r, pass_nxt;

  logic s2_free;   // result register can take a new transfer
  logic s2_take;   // input stage moves into result stage
  logic s1_take;   // input transfer accepted

  assign s2_free  = !out_valid_r || !out_stall;
  assign s2_take  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign s1_take  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // APB port: always ready, writes on the access phase
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr)
      CFG_ADDR_PRG_COUNT: prdata = {24'd0, prg_count_r};
      CFG_ADDR_CHR_COUNT: prdata = {24'd0, chr_count_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r <= PRG_COUNT_RST;
      chr_count_r <= CHR_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr == CFG_ADDR_PRG_COUNT) prg_count_r <= pwdata[7:0];
      if (paddr == CFG_ADDR_CHR_COUNT) chr_count_r <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Address translation, from the bank state before this access
  // ---------------------------------------------------------------------------
  logic [MapW-1:0] a_ext;
  logic [MapW-1:0] cpu_map;
  logic [MapW-1:0] ppu_map;
  logic [1:0]      prg_mode;
  logic [3:0]      prg_bank;
  logic [7:0]      last_bank;

  assign a_ext     = {7'd0, s1_addr_r};
  assign prg_mode  = ctrl_r[3:2];
  assign prg_bank  = prg_r[3:0];   // bit 4 does not select a bank
  assign last_bank = prg_count_r - 8'd1;

  always_comb begin
    if (!s1_addr_r[15]) begin
      cpu_map = a_ext;
    end else if (!prg_mode[1]) begin
      // 32 KB switching
      cpu_map = a_ext + {5'd0, prg_bank[3:1], 15'd0};
    end else if (prg_mode == 2'd2) begin
      // first bank fixed, upper half switched
      if (s1_addr_r[15:14] != 2'b11) begin
        cpu_map = a_ext;
      end else begin
        cpu_map = a_ext - BANK16_OFS + {5'd0, prg_bank, 14'd0};
      end
    end else begin
      // lower half switched, last bank fixed
      if (s1_addr_r[15:14] == 2'b11) begin
        cpu_map = a_ext - BANK16_OFS + {1'b0, last_bank, 14'd0};
      end else begin
        cpu_map = a_ext + {5'd0, prg_bank, 14'd0};
      end
    end
  end

  always_comb begin
    if (ctrl_r[4]) begin
      // two 4 KB banks
      if (!s1_addr_r[12]) begin
        ppu_map = {6'd0, chr0_r, 12'd0} + {11'd0, s1_addr_r[11:0]};
      end else begin
        ppu_map = {6'd0, chr1_r, 12'd0} + {11'd0, s1_addr_r[11:0]};
      end
    end else begin
      // one 8 KB bank
      ppu_map = {6'd0, chr0_r[4:1], 13'd0} + {10'd0, s1_addr_r[12:0]};
    end
  end

  // ---------------------------------------------------------------------------
  // Serial loader and result selection
  // ---------------------------------------------------------------------------
  logic [4:0] shifted;
  logic [2:0] count_inc;

  assign shifted   = {s1_data_r[0], shift_r[4:1]};
  assign count_inc = count_r + 3'd1;

  always_comb begin
    shift_nxt  = shift_r;
    count_nxt  = count_r;
    ctrl_nxt   = ctrl_r;
    chr0_nxt   = chr0_r;
    chr1_nxt   = chr1_r;
    prg_nxt    = prg_r;
    mirror_nxt = mirror_r;
    map_nxt    = a_ext;
    pass_nxt   = 1'b1;
    case (s1_cmd_r)
      CMD_CPU_RD: map_nxt = cpu_map;
      CMD_CPU_WR: begin
        if (s1_addr_r[15]) begin
          pass_nxt = 1'b0;
          if (s1_data_r[7]) begin
            // loader reset; forces the fixed-last-bank PRG mode
            shift_nxt = '0;
            count_nxt = '0;
            ctrl_nxt  = ctrl_r | 5'h0C;
          end else if (count_inc != SHIFT_FULL) begin
            shift_nxt = shifted;
            count_nxt = count_inc;
          end else begin
            shift_nxt = '0;
            count_nxt = '0;
            case (slbm_target_t'(s1_addr_r[14:13]))
              TGT_CONTROL: begin
                ctrl_nxt   = shifted;
                mirror_nxt = {1'b0, shifted[1:0]} + 3'd1;
              end
              TGT_CHR0: chr0_nxt = shifted;
              TGT_CHR1: chr1_nxt = shifted;
              TGT_PRG:  prg_nxt  = shifted;
              default:  prg_nxt  = shifted;
            endcase
          end
        end
      end
      CMD_PPU_RD: map_nxt = ppu_map;
      CMD_PPU_WR: begin
        // writes only land in character RAM
        if (chr_count_r != 8'd0) begin
          pass_nxt = 1'b0;
        end else begin
          map_nxt = ppu_map;
        end
      end
      default: map_nxt = a_ext;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      shift_r     <= '0;
      count_r     <= '0;
      ctrl_r      <= CONTROL_RST;
      chr0_r      <= '0;
      chr1_r      <= '0;
      prg_r       <= '0;
      mirror_r    <= MIR_POWERUP;
    end else begin
      if (s1_take) begin
        s1_valid_r <= 1'b1;
      end else if (s2_take) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_take) begin
        out_valid_r <= 1'b1;
        shift_r     <= shift_nxt;
        count_r     <= count_nxt;
        ctrl_r      <= ctrl_nxt;
        chr0_r      <= chr0_nxt;
        chr1_r      <= chr1_nxt;
        prg_r       <= prg_nxt;
        mirror_r    <= mirror_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_cmd_r  <= slbm_cmd_t'(in_command);
      s1_addr_r <= in_address;
      s1_data_r <= in_write_data;
    end
    if (s2_take) begin
      out_map_r  <= map_nxt;
      out_pass_r <= pass_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mapped_address = out_map_r;
  assign out_pass_through   = out_pass_r;
  assign out_mirroring      = mirror_r;

`ifndef SYNTHESIS
  // the loader never holds five bits; the fifth always commits
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("serial bit count out of range");

  // input stage only back-pressures when it holds a transfer
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input stage");

  // mirroring is one of five codes
  a_mirror_code: assert property (@(posedge clk) disable iff (!rst_n)
    mirror_r <= MIR_HORIZ)
    else $error("mirror mode code out of range");

  // loader reset write clears the shifter and forces PRG mode 3
  a_loader_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_take && s1_cmd_r == CMD_CPU_WR && s1_addr_r[15] && s1_data_r[7])
    |=> (ctrl_r[3:2] == 2'b11 && count_r == 3'd0 && out_valid_r && !out_pass_r))
    else $error("loader reset not applied");
`endif

endmodule

### tb/tb_serial_load_bank_mapper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_load_bank_mapper_top
// Self-checking bench for the serial-load bank mapper. A queue of bus
// accesses feeds a clocked driver; a shadow copy of the mapper state
// predicts the translated address, pass-through flag and mirroring of each
// accepted access, and a clocked monitor checks every result transfer in
// order. The bank counts are rewritten between phases, with random gaps and
// stalls on both channels and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_serial_load_bank_mapper_top;
  import slbm_pkg::*;

  // Address map and mapping constants
  localparam int unsigned CPU_ROM_BASE = 32'h8000;
  localparam int unsigned CPU_HI_HALF  = 32'hC000;
  localparam int unsigned BANK16       = 32'h4000;
  localparam int unsigned BANK32       = 32'h8000;
  localparam int unsigned BANK4        = 32'h1000;
  localparam int unsigned BANK8        = 32'h2000;
  localparam int unsigned PPU_MASK     = 32'h1FFF;

  localparam int unsigned ITEMS_PER_PHASE  = 175;
  localparam int unsigned NUM_PHASES       = 6;
  localparam int unsigned LONG_HOLD_AT     = 300;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT      = 500000;

  typedef struct packed {
    slbm_cmd_t        cmd;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } access_t;

  typedef struct packed {
    logic [MapW-1:0] mapped;
    logic            pass;
    slbm_mirror_t    mirror;
  } map_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Access channel
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_command = '0;
  logic [AddrW-1:0] in_address = '0;
  logic [DataW-1:0] in_write_data = '0;

  // Result channel
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [MapW-1:0] out_mapped_address;
  logic            out_pass_through;
  logic [2:0]      out_mirroring;

  // APB configuration port
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [CfgAw-1:0] paddr = '0;
  logic [CfgDw-1:0] pwdata = '0;
  logic [CfgDw-1:0] prdata;
  logic             pready;

  serial_load_bank_mapper_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mapped_address(out_mapped_address),
    .out_pass_through  (out_pass_through),
    .out_mirroring     (out_mirroring),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow mapper state, starting from the reset values
  // ---------------------------------------------------------------------------
  logic [7:0]   prg_count   = PRG_COUNT_RST;
  logic [7:0]   chr_count   = CHR_COUNT_RST;
  logic [4:0]   shift_val   = '0;
  logic [2:0]   shift_cnt   = '0;
  logic [4:0]   control     = CONTROL_RST;
  logic [4:0]   chr_lo_bank = '0;
  logic [4:0]   chr_hi_bank = '0;
  logic [4:0]   prg_bank    = '0;
  slbm_mirror_t mirror_q    = MIR_POWERUP;

  // Pending accesses and results still owed by the block
  access_t     pend_q[$];
  map_result_t owed_q[$];

  // Run bookkeeping
  logic quiet = 1'b0;      // no idling on either side in the last phase
  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_loads = 0;
  int   n_refused = 0;
  int   n_settings = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  // Translate one access and advance the shadow state exactly as the block does.
  // Mapping uses the bank registers as left by earlier accesses; the mirroring
  // reported is the value after this access.
  function automatic map_result_t map_access(access_t acc);
    map_result_t  r;
    int unsigned  a;
    int unsigned  p;
    int unsigned  m;
    logic [1:0]   prg_mode;
    logic [3:0]   bank;
    logic [7:0]   last_bank;
    logic         pass;
    a = acc.addr;
    p = a & PPU_MASK;
    m = a;
    pass = 1'b1;
    prg_mode = control[3:2];
    bank = prg_bank[3:0];          // bit 4 of the PRG register is not a bank bit
    last_bank = prg_count - 8'd1;  // wraps to 255 when the count is zero
    case (acc.cmd)
      CMD_CPU_RD: begin
        if (a >= CPU_ROM_BASE) begin
          if (prg_mode < 2'd2)
            m = a + (bank >> 1) * BANK32;
          else if (prg_mode == 2'd2)
            m = (a < CPU_HI_HALF) ? a : (a - BANK16) + bank * BANK16;
          else if (a >= CPU_HI_HALF)
            m = (a - BANK16) + last_bank * BANK16;
          else
            m = a + bank * BANK16;
        end
      end
      CMD_CPU_WR: begin
        if (a >= CPU_ROM_BASE) begin
          pass = 1'b0;
          if (acc.data[7]) begin
            // Shifter clear also forces PRG mode 3, mirroring untouched
            shift_val = '0;
            shift_cnt = '0;
            control = control | 5'h0C;
          end else begin
            shift_val = {acc.data[0], shift_val[4:1]};
            shift_cnt = shift_cnt + 3'd1;
            if (shift_cnt == SHIFT_FULL) begin
              case (slbm_target_t'(acc.addr[14:13]))
                TGT_CONTROL: begin
                  control = shift_val;
                  mirror_q = slbm_mirror_t'({1'b0, shift_val[1:0]} + 3'd1);
                end
                TGT_CHR0: chr_lo_bank = shift_val;
                TGT_CHR1: chr_hi_bank = shift_val;
                default:  prg_bank = shift_val;
              endcase
              shift_val = '0;
              shift_cnt = '0;
              n_loads++;
            end
          end
        end
      end
      default: begin
        if (acc.cmd == CMD_PPU_WR && chr_count != 8'd0) begin
          // CHR ROM present: write refused, address passed back untouched
          pass = 1'b0;
          n_refused++;
        end else if (control[4]) begin
          m = (p < BANK4) ? p + chr_lo_bank * BANK4 : (p - BANK4) + chr_hi_bank * BANK4;
        end else begin
          m = p + (chr_lo_bank >> 1) * BANK8;
        end
      end
    endcase
    r.mapped = m[MapW-1:0];
    r.pass = pass;
    r.mirror = mirror_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: takes accesses from pend_q, inserts random gaps between them,
  // and predicts each access at the edge where its transfer happens.
  // ---------------------------------------------------------------------------
  access_t on_bus;
  int      gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_q.push_back(map_access(on_bus));
        n_accepted++;
      end
      // Payload only moves when the slot is empty or was just taken
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          on_bus = pend_q.pop_front();
          in_command <= on_bus.cmd;
          in_address <= on_bus.addr;
          in_write_data <= on_bus.data;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction and
  // drives the stall side: short random bursts, plus one long hold while the
  // driver keeps offering so the block backs up into in_stall.
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk) begin
    map_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("result transfer with nothing outstanding: addr %0h pass %0d mirror %0d",
                 out_mapped_address, out_pass_through, out_mirroring);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (out_mapped_address !== want.mapped) begin
            $error("mapped_address: expected %0h, actual %0h", want.mapped,
                   out_mapped_address);
            mismatches++;
          end
          if (out_pass_through !== want.pass) begin
            $error("pass_through: expected %0d, actual %0d", want.pass, out_pass_through);
            mismatches++;
          end
          if (out_mirroring !== want.mirror) begin
            $error("mirroring: expected %0d, actual %0d", want.mirror, out_mirroring);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && n_accepted >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(slbm_cmd_t cmd, logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    access_t acc;
    acc.cmd = cmd;
    acc.addr = addr;
    acc.data = data;
    pend_q.push_back(acc);
    n_queued++;
  endtask

  // A read on either bus, or a PPU write; CPU reads lean toward ROM space, PPU toward pattern space
  task automatic queue_read();
    if ($urandom_range(0, 1) == 1)
      queue_item(CMD_CPU_RD, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : {1'b1, 15'($urandom)},
                 8'($urandom));
    else
      queue_item(($urandom_range(0, 1) == 1) ? CMD_PPU_RD : CMD_PPU_WR,
                 ($urandom_range(0, 7) == 0) ? 16'($urandom) : {3'b000, 13'($urandom)},
                 8'($urandom));
  endtask

  // Five serial writes that load one register; only the fifth address picks
  // the target. With mix set, reads may land before or between the writes.
  task automatic queue_load(slbm_target_t target, logic [4:0] value, logic mix);
    for (int i = 0; i < 5; i++) begin
      if (mix && $urandom_range(0, 3) == 0)
        queue_read();
      queue_item(CMD_CPU_WR,
                 (i == 4) ? {1'b1, target, 13'($urandom)} : {1'b1, 15'($urandom)},
                 {1'b0, 6'($urandom), value[i]});
    end
  endtask

  // Mostly well-formed loads and reads; some aborted loads and raw noise
  task automatic queue_random(int count);
    int stop;
    int pick;
    stop = n_queued + count;
    while (n_queued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_load(slbm_target_t'($urandom_range(0, 3)), 5'($urandom), 1'b1);
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 4))
          queue_item(CMD_CPU_WR, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
        queue_item(CMD_CPU_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
      end else if (pick < 85) begin
        queue_read();
      end else begin
        queue_item(slbm_cmd_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // Wait until nothing is queued, in flight or owed
  task automatic wait_drained();
    int idle_run;
    idle_run = 0;
    while (idle_run < 4) begin
      @(posedge clk);
      if (pend_q.size() == 0 && owed_q.size() == 0 && !in_valid && !out_valid)
        idle_run++;
      else
        idle_run = 0;
    end
  endtask

  // APB write of one bank count, then read it back
  task automatic write_bank_count(logic [CfgAw-1:0] reg_addr, logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= reg_addr;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, value}) begin
      $error("prdata at %0h: expected %0h, actual %0h", reg_addr, value, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_addr == CFG_ADDR_PRG_COUNT)
      prg_count = value;
    else
      chr_count = value;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] prg_set;
    logic [7:0] chr_set;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed accesses under the reset bank counts (PRG mode 3, CHR RAM)
    queue_item(CMD_CPU_RD, 16'h0000, 8'h00);
    queue_item(CMD_CPU_RD, 16'h7FFF, 8'hFF);
    queue_item(CMD_CPU_RD, 16'hFFFF, 8'h00);   // fixed last bank
    queue_item(CMD_CPU_WR, 16'h7FFF, 8'hFF);   // below ROM, passed through
    queue_item(CMD_CPU_WR, 16'h8000, 8'h80);   // shifter clear
    queue_load(TGT_CONTROL, 5'b11011, 1'b0);   // 4K CHR, PRG mode 2, horizontal
    queue_load(TGT_PRG, 5'b10011, 1'b0);       // bank bit 4 set but unused
    queue_item(CMD_CPU_RD, 16'h8000, 8'h00);
    queue_item(CMD_CPU_RD, 16'hC000, 8'h00);
    queue_item(CMD_PPU_RD, 16'h0FFF, 8'h00);
    queue_item(CMD_PPU_RD, 16'hFFFF, 8'h00);   // above pattern space
    queue_item(CMD_PPU_WR, 16'h1000, 8'h5A);   // CHR RAM write allowed
    queue_item(CMD_CPU_WR, 16'hA000, 8'h01);   // partial load ...
    queue_item(CMD_CPU_WR, 16'hA000, 8'h80);   // ... aborted by a clear
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin prg_set = 8'd1;   chr_set = 8'd0;   end
        1: begin prg_set = 8'd0;   chr_set = 8'd255; end
        2: begin prg_set = 8'd255; chr_set = 8'd1;   end
        3: begin prg_set = 8'd8;   chr_set = 8'd0;   end
        4: begin prg_set = 8'($urandom_range(1, 255)); chr_set = 8'($urandom); end
        default: begin prg_set = 8'd16; chr_set = 8'd0; end
      endcase
      write_bank_count(CFG_ADDR_PRG_COUNT, prg_set);
      write_bank_count(CFG_ADDR_CHR_COUNT, chr_set);
      n_settings++;
      if (p == 1) begin
        // Zero PRG count wraps the fixed bank; CHR ROM refuses PPU writes
        queue_item(CMD_CPU_WR, 16'hFFFF, 8'hFF);
        queue_item(CMD_CPU_RD, 16'hFFFF, 8'h00);
        queue_item(CMD_CPU_RD, 16'hC000, 8'h00);
        queue_item(CMD_PPU_WR, 16'h1FFF, 8'hA5);
      end
      if (p == NUM_PHASES - 1)
        quiet <= 1'b1;
      queue_random(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("Covered %0d accesses under %0d bank-count settings, %0d register loads",
             n_accepted, n_settings + 1, n_loads);
    $display("%0d refused CHR writes, %0d mismatches", n_refused, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
